FILE: rtl/gtbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbs_pkg: shared types and codes of the gain trim bracket search
// Register indexes, item op codes, end cause codes and the bundles that
// travel between the step logic, the register file and the top level.
// ----------------------------------------------------------------------------
package gtbs_pkg;

    localparam int GainW   = 8;
    localparam int LevelW  = 16;
    localparam int CauseW  = 4;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_REF_LEVEL  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_STEP_SIZE  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GAIN_UPPER = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_GAIN_LOWER = 2'd3;

    // register reset values
    localparam logic [LevelW-1:0] REF_LEVEL_RST  = 16'd32768;
    localparam logic [GainW-1:0]  STEP_SIZE_RST  = 8'd1;
    localparam logic [GainW-1:0]  GAIN_UPPER_RST = 8'd255;
    localparam logic [GainW-1:0]  GAIN_LOWER_RST = 8'd0;

    // item op codes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // end cause codes
    localparam logic [CauseW-1:0] CAUSE_SEARCHING  = 4'd0;
    localparam logic [CauseW-1:0] CAUSE_EXACT      = 4'd1;
    localparam logic [CauseW-1:0] CAUSE_MAX_FIRST  = 4'd2;
    localparam logic [CauseW-1:0] CAUSE_CUR_BELOW  = 4'd3;
    localparam logic [CauseW-1:0] CAUSE_PREV_BELOW = 4'd4;
    localparam logic [CauseW-1:0] CAUSE_MAX        = 4'd5;
    localparam logic [CauseW-1:0] CAUSE_MIN_FIRST  = 4'd6;
    localparam logic [CauseW-1:0] CAUSE_CUR_ABOVE  = 4'd7;
    localparam logic [CauseW-1:0] CAUSE_PREV_ABOVE = 4'd8;
    localparam logic [CauseW-1:0] CAUSE_MIN        = 4'd9;

    typedef struct packed {
        logic [LevelW-1:0] ref_level;
        logic [GainW-1:0]  step_size;
        logic [GainW-1:0]  gain_upper;
        logic [GainW-1:0]  gain_lower;
    } cfg_t;

    typedef struct packed {
        logic [GainW-1:0]  current_gain;
        logic              has_previous;
        logic [GainW-1:0]  previous_gain;
        logic [LevelW-1:0] previous_reading;
        logic [CauseW-1:0] finish_code;
    } search_t;

    typedef struct packed {
        logic [GainW-1:0]  gain_out;
        logic              done_res;
        logic [CauseW-1:0] end_cause;
    } result_t;

endpackage

FILE: rtl/gtbs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbs_cfg_regs: configuration register file
// Four write-only registers loaded through a plain write port.
// ----------------------------------------------------------------------------
module gtbs_cfg_regs
    import gtbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_level  <= REF_LEVEL_RST;
            cfg_reg.step_size  <= STEP_SIZE_RST;
            cfg_reg.gain_upper <= GAIN_UPPER_RST;
            cfg_reg.gain_lower <= GAIN_LOWER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_LEVEL:  cfg_reg.ref_level  <= cfg_wdata;
                REG_STEP_SIZE:  cfg_reg.step_size  <= cfg_wdata[GainW-1:0];
                REG_GAIN_UPPER: cfg_reg.gain_upper <= cfg_wdata[GainW-1:0];
                REG_GAIN_LOWER: cfg_reg.gain_lower <= cfg_wdata[GainW-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/gtbs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbs_step: one search step
// From the current search state and one item, form the next state and the
// result item. Pure combinational logic.
// ----------------------------------------------------------------------------
module gtbs_step
    import gtbs_pkg::*;
(
    input  cfg_t              cfg,
    input  search_t           cur,
    input  logic              op,
    input  logic [GainW-1:0]  start_gain,
    input  logic [LevelW-1:0] ad_sample,
    output search_t           nxt,
    output result_t           res
);

    logic [GainW:0]    up_sum;
    logic [GainW-1:0]  up_gain;
    logic [GainW-1:0]  dn_diff;
    logic [GainW-1:0]  dn_gain;
    logic [LevelW-1:0] below_gap;
    logic [LevelW-1:0] prev_above_gap;
    logic [LevelW-1:0] above_gap;
    logic [LevelW-1:0] prev_below_gap;
    logic              first;

    // clamped step up and step down
    always_comb
    begin
        up_sum  = {1'b0, cur.current_gain} + {1'b0, cfg.step_size};
        up_gain = (up_sum > {1'b0, cfg.gain_upper}) ? cfg.gain_upper : up_sum[GainW-1:0];
        dn_diff = cur.current_gain - cfg.step_size;
        dn_gain = ((cur.current_gain < cfg.step_size) || (dn_diff < cfg.gain_lower))
                  ? cfg.gain_lower : dn_diff;
    end

    // distances to the reference on both sides
    always_comb
    begin
        below_gap      = cfg.ref_level - ad_sample;
        prev_above_gap = cur.previous_reading - cfg.ref_level;
        above_gap      = ad_sample - cfg.ref_level;
        prev_below_gap = cfg.ref_level - cur.previous_reading;
    end

    always_comb
    begin
        nxt   = cur;
        first = !cur.has_previous;
        if (op == OP_START)
        begin
            nxt.current_gain     = start_gain;
            nxt.has_previous     = 1'b0;
            nxt.previous_gain    = '0;
            nxt.previous_reading = '0;
            nxt.finish_code      = CAUSE_SEARCHING;
        end
        else if (cur.finish_code == CAUSE_SEARCHING)
        begin
            nxt.has_previous = 1'b1;
            if (ad_sample == cfg.ref_level)
            begin
                nxt.finish_code = CAUSE_EXACT;
            end
            else if (ad_sample < cfg.ref_level)
            begin
                if (!first && (cur.previous_reading >= cfg.ref_level))
                begin
                    if (below_gap < prev_above_gap)
                    begin
                        nxt.finish_code = CAUSE_CUR_BELOW;
                    end
                    else
                    begin
                        nxt.current_gain = cur.previous_gain;
                        nxt.finish_code  = CAUSE_PREV_BELOW;
                    end
                end
                else if (cur.current_gain >= cfg.gain_upper)
                begin
                    nxt.finish_code = first ? CAUSE_MAX_FIRST : CAUSE_MAX;
                end
                else
                begin
                    nxt.previous_gain    = cur.current_gain;
                    nxt.previous_reading = ad_sample;
                    nxt.current_gain     = up_gain;
                end
            end
            else
            begin
                if (!first && (cur.previous_reading <= cfg.ref_level))
                begin
                    if (above_gap <= prev_below_gap)
                    begin
                        nxt.finish_code = CAUSE_CUR_ABOVE;
                    end
                    else
                    begin
                        nxt.current_gain = cur.previous_gain;
                        nxt.finish_code  = CAUSE_PREV_ABOVE;
                    end
                end
                else if (cur.current_gain <= cfg.gain_lower)
                begin
                    nxt.finish_code = first ? CAUSE_MIN_FIRST : CAUSE_MIN;
                end
                else
                begin
                    nxt.previous_gain    = cur.current_gain;
                    nxt.previous_reading = ad_sample;
                    nxt.current_gain     = dn_gain;
                end
            end
        end
    end

    always_comb
    begin
        res.gain_out  = nxt.current_gain;
        res.done_res  = (nxt.finish_code != CAUSE_SEARCHING);
        res.end_cause = nxt.finish_code;
    end

endmodule

FILE: rtl/gtbs_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbs_out_buf: result register with skid stage
// Hold the result item for the consumer; park one more in the skid stage
// while the output is stalled.
// ----------------------------------------------------------------------------
module gtbs_out_buf
    import gtbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/gain_trim_bracket_search.sv
`timescale 1ns / 1ps
// Output: the result item of an accepted item is registered before it reaches the outputs.
// Throughput: one item per cycle while in_stall is low; the search state updates at the accept edge.
// The result register plus a one-entry skid stage absorb a single output stall
// before in_stall rises.
// Reset: asynchronous, active low; search state clears, registers take defaults.
// ----------------------------------------------------------------------------
// gain_trim_bracket_search: gain trim calibration by stepwise bracket search
// A start item loads the gain; each sample item of a running search steps
// the gain toward the reference or ends the search on a crossing, exact match or limit.
// ----------------------------------------------------------------------------
module gain_trim_bracket_search
    import gtbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    // input item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [GainW-1:0]   start_gain,
    input  logic [LevelW-1:0]  ad_sample,
    // result item channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [GainW-1:0]   gain_out,
    output logic               done_res,
    output logic [CauseW-1:0]  end_cause
);

    cfg_t    cfg;
    search_t search_reg;
    search_t search_next;
    result_t step_res;
    result_t out_data;
    logic    buf_full;
    logic    in_accept;

    // Stall only once the skid stage is occupied; a single pending result
    // never blocks the input side.
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    gtbs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Next search state and result for the item at the ports.
    gtbs_step u_step (
        .cfg        (cfg),
        .cur        (search_reg),
        .op         (op),
        .start_gain (start_gain),
        .ad_sample  (ad_sample),
        .nxt        (search_next),
        .res        (step_res)
    );

    // Advance the search state only on an accepted item, so the next item
    // in the following cycle already sees the updated gain and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_reg <= '0;
        end
        else if (in_accept)
        begin
            search_reg <= search_next;
        end
    end

    gtbs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (step_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign gain_out  = out_data.gain_out;
    assign done_res  = out_data.done_res;
    assign end_cause = out_data.end_cause;

endmodule
